[hdl/key_press_duration_classifier_unit_defines.svh]
// Assertion macros shared by the key press duration classifier modules.
// Each macro expects clk_i and rst_ni in the scope where it is used.
`ifndef KEY_PRESS_DURATION_CLASSIFIER_UNIT_DEFINES_SVH
`define KEY_PRESS_DURATION_CLASSIFIER_UNIT_DEFINES_SVH

// Clocked assertion, switched off while reset is asserted.
`define KPDC_ASSERT(lbl, prop, msg) \
  lbl: assert property (@(posedge clk_i) disable iff (!rst_ni) prop) \
    else $error(msg);

// Clocked implication between an antecedent and a consequent.
`define KPDC_ASSERT_IMPL(lbl, ante, cons, msg) \
  `KPDC_ASSERT(lbl, (ante) |-> (cons), msg)

`endif

[hdl/kpdc_pkg.sv]
// Types, codes and constants of the key press duration classifier.
// Used by the lane, merge and top-level modules; depends on nothing.
package kpdc_pkg;

  localparam int unsigned LEVEL_W = 2;
  localparam int unsigned THR_W   = 8;
  localparam int unsigned CNT_W   = 8;
  localparam int unsigned CFG_IDX_W = 2;

  localparam logic [CNT_W-1:0] HOLD_CAP = 8'd239;

  localparam logic [THR_W-1:0] PRESS_TH_RST = 8'd2;
  localparam logic [THR_W-1:0] LONG_TH_RST  = 8'd64;
  localparam logic [THR_W-1:0] VLONG_TH_RST = 8'd175;

  typedef enum logic [CFG_IDX_W-1:0] {
    CFG_PRESS_TH = 2'd0,
    CFG_LONG_TH  = 2'd1,
    CFG_VLONG_TH = 2'd2
  } cfg_reg_e;

  typedef enum logic [2:0] {
    KIND_PRESS       = 3'd0,
    KIND_LONG        = 3'd1,
    KIND_VLONG       = 3'd2,
    KIND_REL_SHORT   = 3'd3,
    KIND_REL_LONG    = 3'd4,
    KIND_REL_VLONG   = 3'd5
  } kind_e;

  typedef enum logic [1:0] {
    CLS_SHORT = 2'd0,
    CLS_LONG  = 2'd1,
    CLS_VLONG = 2'd2
  } press_cls_e;

  typedef struct packed {
    logic [THR_W-1:0] press;
    logic [THR_W-1:0] lng;
    logic [THR_W-1:0] vlong;
  } thr_t;

  typedef struct packed {
    logic [2:0] trig;
    logic       rel;
    press_cls_e cls;
  } lane_ev_t;

  function automatic kind_e rel_kind(press_cls_e c);
    kind_e k;
    case (c)
      CLS_LONG:  k = KIND_REL_LONG;
      CLS_VLONG: k = KIND_REL_VLONG;
      default:   k = KIND_REL_SHORT;
    endcase
    return k;
  endfunction

endpackage

[hdl/kpdc_lane.sv]
// One key's hold counter, fired marks and press class, updated per scan tick.
// Depends on kpdc_pkg and the assertion macros header.
`include "key_press_duration_classifier_unit_defines.svh"

module kpdc_lane (
  input  logic               clk_i,
  input  logic               rst_ni,
  input  logic               load_i,
  input  logic               released_i,
  input  kpdc_pkg::thr_t     thr_i,
  output kpdc_pkg::lane_ev_t ev_o
);

  logic [kpdc_pkg::CNT_W-1:0] cnt_q, cnt_d, cnt_new;
  logic [2:0]                 fired_q, fired_d, fired_new, hit;
  kpdc_pkg::press_cls_e       cls_q, cls_d, cls_new;

  always_comb begin
    cnt_new = cnt_q;
    if (!released_i && (cnt_q < kpdc_pkg::HOLD_CAP)) begin
      cnt_new = cnt_q + kpdc_pkg::CNT_W'(1);
    end
    hit[0] = cnt_new > thr_i.press;
    hit[1] = hit[0] && (cnt_new > thr_i.lng);
    hit[2] = hit[0] && (cnt_new > thr_i.vlong);
    fired_new = fired_q | hit;
    cls_new = cls_q;
    if (hit[2]) begin
      cls_new = kpdc_pkg::CLS_VLONG;
    end else if (hit[1]) begin
      cls_new = kpdc_pkg::CLS_LONG;
    end else if (hit[0]) begin
      cls_new = kpdc_pkg::CLS_SHORT;
    end
    ev_o.trig = hit & ~fired_q;
    ev_o.rel  = released_i && (fired_new != 3'b000);
    ev_o.cls  = cls_new;
  end

  always_comb begin
    cnt_d   = cnt_q;
    fired_d = fired_q;
    cls_d   = cls_q;
    if (load_i) begin
      cls_d   = cls_new;
      cnt_d   = released_i ? '0 : cnt_new;
      fired_d = released_i ? 3'b000 : fired_new;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      cnt_q   <= '0;
      fired_q <= 3'b000;
      cls_q   <= kpdc_pkg::CLS_SHORT;
    end else begin
      cnt_q   <= cnt_d;
      fired_q <= fired_d;
      cls_q   <= cls_d;
    end
  end

  `KPDC_ASSERT_IMPL(a_fired_needs_count, fired_q != 3'b000, cnt_q != '0, "fired marks without count")
  `KPDC_ASSERT_IMPL(a_vlong_after_press, fired_q[2] || fired_q[1], fired_q[0], "level fired before press")

endmodule

[hdl/kpdc_merge.sv]
// Merges the lane events of one tick in order and hands them out one per transfer.
// Depends on kpdc_pkg and the assertion macros header.
`include "key_press_duration_classifier_unit_defines.svh"

module kpdc_merge #(
  parameter int unsigned KEY_COUNT = 2
) (
  input  logic                 clk_i,
  input  logic                 rst_ni,
  input  logic                 load_i,
  input  kpdc_pkg::lane_ev_t   ev_i [KEY_COUNT],
  output logic                 in_stall_o,
  output logic                 out_valid_o,
  input  logic                 out_stall_i,
  output logic                 event_key_o,
  output logic [2:0]           event_kind_o,
  output logic                 last_event_o
);

  localparam int unsigned TW = 3 * KEY_COUNT;
  localparam int unsigned EW = TW + KEY_COUNT;

  logic [EW-1:0]        ev_q, ev_d, ld_vec, pick, rest;
  kpdc_pkg::press_cls_e cls_q [KEY_COUNT];
  logic                 cnt_q, cnt_d;
  logic                 pend_v, take, last;
  logic                 sel_key;
  kpdc_pkg::kind_e      sel_kind;

  logic                 out_valid_q, out_valid_d;
  logic                 out_key_q, out_last_q;
  kpdc_pkg::kind_e      out_kind_q;

  always_comb begin
    ld_vec = '0;
    for (int k = 0; k < KEY_COUNT; k++) begin
      ld_vec[3*k +: 3] = ev_i[k].trig;
      ld_vec[TW + k]   = ev_i[k].rel;
    end
  end

  always_comb begin
    pend_v = |ev_q;
    take   = !out_valid_q || !out_stall_i;
    pick   = ev_q & (~ev_q + EW'(1));
    rest   = ev_q & ~pick;
    last   = cnt_q || (rest == '0);
    sel_key  = 1'b0;
    sel_kind = kpdc_pkg::KIND_PRESS;
    for (int k = 0; k < KEY_COUNT; k++) begin
      for (int j = 0; j < 3; j++) begin
        if (pick[3*k + j]) begin
          sel_key  = 1'(k);
          sel_kind = kpdc_pkg::kind_e'(3'(j));
        end
      end
      if (pick[TW + k]) begin
        sel_key  = 1'(k);
        sel_kind = kpdc_pkg::rel_kind(cls_q[k]);
      end
    end
  end

  always_comb begin
    ev_d  = ev_q;
    cnt_d = cnt_q;
    if (take && pend_v) begin
      ev_d  = last ? '0 : rest;
      cnt_d = !last;
    end
    if (load_i) begin
      ev_d  = ld_vec;
      cnt_d = 1'b0;
    end
    out_valid_d = take ? pend_v : out_valid_q;
    in_stall_o  = pend_v && !(take && last);
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      ev_q        <= '0;
      cnt_q       <= 1'b0;
      out_valid_q <= 1'b0;
    end else begin
      ev_q        <= ev_d;
      cnt_q       <= cnt_d;
      out_valid_q <= out_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    if (load_i) begin
      for (int k = 0; k < KEY_COUNT; k++) begin
        cls_q[k] <= ev_i[k].cls;
      end
    end
    if (take && pend_v) begin
      out_key_q  <= sel_key;
      out_kind_q <= sel_kind;
      out_last_q <= last;
    end
  end

  assign out_valid_o  = out_valid_q;
  assign event_key_o  = out_key_q;
  assign event_kind_o = out_kind_q;
  assign last_event_o = out_last_q;

  `KPDC_ASSERT_IMPL(a_more_after_nonlast, out_valid_q && !out_last_q, pend_v, "non-final result without a pending one")
  `KPDC_ASSERT_IMPL(a_second_needs_pending, cnt_q, pend_v, "second-result count without pending events")

endmodule

[hdl/key_press_duration_classifier_unit.sv]
// Key press duration classifier: one scan tick in, up to two key events out.
// Depends on kpdc_pkg, kpdc_lane, kpdc_merge and the assertion macros header.
//
// Input channel: in_valid_i, in_stall_o and key_levels_i (bit k low means
// key k is pressed). A transfer happens when in_valid_i is high and
// in_stall_o is low. Output channel: out_valid_o, out_stall_i and the event
// fields; last_event_o marks the final event of a tick. A tick that causes
// no event produces no output transfer.
// Each key has its own lane that updates its counter and marks at the
// transfer. The events of a tick wait in the pending stage and then pass
// through the output register, which issues one event per cycle while the
// receiver does not stall; a new tick is accepted when nothing is pending
// or when the last pending event moves to the output register. The threshold
// registers are written through cfg_we_i, cfg_idx_i and cfg_wdata_i; the user
// must write them only while the unit is idle, which the unit does not
// enforce. Writes to index 3 are ignored. Reset clears all counters, marks
// and pending events and restores the default thresholds. While the receiver
// stalls, the presented event holds and ticks are accepted until one that
// causes events waits in the pending stage.
`include "key_press_duration_classifier_unit_defines.svh"

module key_press_duration_classifier_unit #(
  parameter int unsigned KEY_COUNT = 2
) (
  input  logic                                clk_i,
  input  logic                                rst_ni,
  input  logic                                cfg_we_i,
  input  logic [kpdc_pkg::CFG_IDX_W-1:0]      cfg_idx_i,
  input  logic [kpdc_pkg::THR_W-1:0]          cfg_wdata_i,
  input  logic                                in_valid_i,
  output logic                                in_stall_o,
  input  logic [kpdc_pkg::LEVEL_W-1:0]        key_levels_i,
  output logic                                out_valid_o,
  input  logic                                out_stall_i,
  output logic                                event_key_o,
  output logic [2:0]                          event_kind_o,
  output logic                                last_event_o
);

  kpdc_pkg::thr_t     thr_q, thr_d;
  kpdc_pkg::lane_ev_t lane_ev [KEY_COUNT];
  logic               accept;

  assign accept = in_valid_i && !in_stall_o;

  always_comb begin
    thr_d = thr_q;
    if (cfg_we_i) begin
      case (kpdc_pkg::cfg_reg_e'(cfg_idx_i))
        kpdc_pkg::CFG_PRESS_TH: thr_d.press = cfg_wdata_i;
        kpdc_pkg::CFG_LONG_TH:  thr_d.lng   = cfg_wdata_i;
        kpdc_pkg::CFG_VLONG_TH: thr_d.vlong = cfg_wdata_i;
        default:                thr_d       = thr_q;
      endcase
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      thr_q.press <= kpdc_pkg::PRESS_TH_RST;
      thr_q.lng   <= kpdc_pkg::LONG_TH_RST;
      thr_q.vlong <= kpdc_pkg::VLONG_TH_RST;
    end else begin
      thr_q <= thr_d;
    end
  end

  for (genvar k = 0; k < KEY_COUNT; k++) begin : g_lane
    logic rel_lvl;
    if (k < kpdc_pkg::LEVEL_W) begin : g_pin
      assign rel_lvl = key_levels_i[k];
    end else begin : g_tied
      assign rel_lvl = 1'b0;
    end
    kpdc_lane u_lane (
      .clk_i      (clk_i),
      .rst_ni     (rst_ni),
      .load_i     (accept),
      .released_i (rel_lvl),
      .thr_i      (thr_q),
      .ev_o       (lane_ev[k])
    );
  end

  kpdc_merge #(
    .KEY_COUNT (KEY_COUNT)
  ) u_merge (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .load_i       (accept),
    .ev_i         (lane_ev),
    .in_stall_o   (in_stall_o),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_key_o  (event_key_o),
    .event_kind_o (event_kind_o),
    .last_event_o (last_event_o)
  );

  `KPDC_ASSERT_IMPL(a_no_out_without_tick, $rose(out_valid_o), $past(accept, 2), "result without a tick")

endmodule

[sim/key_press_duration_classifier_unit_test.sv]
// Testbench for key_press_duration_classifier_unit: drives scan ticks, predicts the key events
// with its own model of the hold counters and compares every output transfer in order.
// Depends on kpdc_pkg and the unit under test; needs nothing else.
module key_press_duration_classifier_unit_test;
  timeunit 1ns;
  timeprecision 1ps;

  localparam logic [kpdc_pkg::CFG_IDX_W-1:0] CFG_UNUSED_IDX = 2'd3;
  localparam int unsigned DRAIN_LIMIT = 5000;
  localparam int unsigned SETTLE_CYCLES = 10;

  typedef struct packed {
    logic            key;
    kpdc_pkg::kind_e kind;
    logic            last;
  } key_event_t;

  logic                           clk_i        = 1'b0;
  logic                           rst_ni       = 1'b0;
  logic                           cfg_we_i     = 1'b0;
  logic [kpdc_pkg::CFG_IDX_W-1:0] cfg_idx_i    = '0;
  logic [kpdc_pkg::THR_W-1:0]     cfg_wdata_i  = '0;
  logic                           in_valid_i   = 1'b0;
  logic                           in_stall_o;
  logic [kpdc_pkg::LEVEL_W-1:0]   key_levels_i = '1;
  logic                           out_valid_o;
  logic                           out_stall_i  = 1'b0;
  logic                           event_key_o;
  logic [2:0]                     event_kind_o;
  logic                           last_event_o;

  int unsigned send_idle_pct = 0;
  int unsigned recv_idle_pct = 0;
  int unsigned fail_count    = 0;

  key_event_t pending_events[$];

  logic [kpdc_pkg::THR_W-1:0] thr_press = kpdc_pkg::PRESS_TH_RST;
  logic [kpdc_pkg::THR_W-1:0] thr_long  = kpdc_pkg::LONG_TH_RST;
  logic [kpdc_pkg::THR_W-1:0] thr_vlong = kpdc_pkg::VLONG_TH_RST;
  logic [kpdc_pkg::CNT_W-1:0] hold_cnt   [2] = '{default: '0};
  logic [2:0]                 fired_mask [2] = '{default: '0};
  kpdc_pkg::press_cls_e       held_class [2] = '{default: kpdc_pkg::CLS_SHORT};

  int unsigned run_left [2] = '{default: 0};
  logic [1:0]  key_down = 2'b00;

  key_press_duration_classifier_unit dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .cfg_we_i     (cfg_we_i),
    .cfg_idx_i    (cfg_idx_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .in_valid_i   (in_valid_i),
    .in_stall_o   (in_stall_o),
    .key_levels_i (key_levels_i),
    .out_valid_o  (out_valid_o),
    .out_stall_i  (out_stall_i),
    .event_key_o  (event_key_o),
    .event_kind_o (event_kind_o),
    .last_event_o (last_event_o)
  );

  always #5 clk_i = ~clk_i;

  always @(posedge clk_i) begin
    out_stall_i <= ($urandom_range(99) < recv_idle_pct);
  end

  always @(posedge clk_i) begin
    key_event_t want;
    if (rst_ni && out_valid_o && !out_stall_i) begin
      if (pending_events.size() == 0) begin
        fail_count++;
        if (fail_count <= 10)
          $display("unexpected event: key %0d kind %0d last %0d",
                   event_key_o, event_kind_o, last_event_o);
      end else begin
        want = pending_events.pop_front();
        if (event_key_o !== want.key || event_kind_o !== want.kind ||
            last_event_o !== want.last) begin
          fail_count++;
          if (fail_count <= 10)
            $display("event mismatch: expected key %0d kind %0d last %0d, got key %0d kind %0d last %0d",
                     want.key, want.kind, want.last, event_key_o, event_kind_o, last_event_o);
        end
      end
    end
  end

  task automatic predict_tick(input logic [1:0] lv);
    key_event_t tick_evs[$];
    kpdc_pkg::kind_e rel;
    for (int k = 0; k < 2; k++)
      if (!lv[k] && hold_cnt[k] < kpdc_pkg::HOLD_CAP) hold_cnt[k] = hold_cnt[k] + 8'd1;
    for (int k = 0; k < 2; k++) begin
      if (hold_cnt[k] > thr_press) begin
        held_class[k] = kpdc_pkg::CLS_SHORT;
        if (!fired_mask[k][0]) begin
          fired_mask[k][0] = 1'b1;
          tick_evs.push_back('{1'(k), kpdc_pkg::KIND_PRESS, 1'b0});
        end
        if (hold_cnt[k] > thr_long) begin
          held_class[k] = kpdc_pkg::CLS_LONG;
          if (!fired_mask[k][1]) begin
            fired_mask[k][1] = 1'b1;
            tick_evs.push_back('{1'(k), kpdc_pkg::KIND_LONG, 1'b0});
          end
        end
        if (hold_cnt[k] > thr_vlong) begin
          held_class[k] = kpdc_pkg::CLS_VLONG;
          if (!fired_mask[k][2]) begin
            fired_mask[k][2] = 1'b1;
            tick_evs.push_back('{1'(k), kpdc_pkg::KIND_VLONG, 1'b0});
          end
        end
      end
    end
    for (int k = 0; k < 2; k++) begin
      if (lv[k]) begin
        if (fired_mask[k] != 3'b000) begin
          fired_mask[k] = 3'b000;
          case (held_class[k])
            kpdc_pkg::CLS_LONG:  rel = kpdc_pkg::KIND_REL_LONG;
            kpdc_pkg::CLS_VLONG: rel = kpdc_pkg::KIND_REL_VLONG;
            default:             rel = kpdc_pkg::KIND_REL_SHORT;
          endcase
          tick_evs.push_back('{1'(k), rel, 1'b0});
        end
        hold_cnt[k] = '0;
      end
    end
    while (tick_evs.size() > 2) void'(tick_evs.pop_back());
    if (tick_evs.size() > 0) tick_evs[tick_evs.size()-1].last = 1'b1;
    foreach (tick_evs[i]) pending_events.push_back(tick_evs[i]);
  endtask

  task automatic send_tick(input logic [1:0] lv);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid_i <= 1'b0;
      @(posedge clk_i);
    end
    in_valid_i   <= 1'b1;
    key_levels_i <= lv;
    predict_tick(lv);
    do @(posedge clk_i); while (in_stall_o);
  endtask

  task automatic settle();
    int unsigned waited;
    in_valid_i <= 1'b0;
    waited = 0;
    while (pending_events.size() != 0 && waited < DRAIN_LIMIT) begin
      @(posedge clk_i);
      waited++;
    end
    if (pending_events.size() != 0) begin
      fail_count++;
      if (fail_count <= 10)
        $display("%0d expected events never arrived", pending_events.size());
      pending_events.delete();
    end
    repeat (SETTLE_CYCLES) @(posedge clk_i);
  endtask

  task automatic write_cfg(input logic [kpdc_pkg::CFG_IDX_W-1:0] idx,
                           input logic [kpdc_pkg::THR_W-1:0] val, input bit more);
    cfg_we_i    <= 1'b1;
    cfg_idx_i   <= idx;
    cfg_wdata_i <= val;
    @(posedge clk_i);
    if (!more) cfg_we_i <= 1'b0;
    case (idx)
      kpdc_pkg::CFG_PRESS_TH: thr_press = val;
      kpdc_pkg::CFG_LONG_TH:  thr_long  = val;
      kpdc_pkg::CFG_VLONG_TH: thr_vlong = val;
      default: ;
    endcase
  endtask

  task automatic set_thresholds(input logic [7:0] p, input logic [7:0] l, input logic [7:0] v);
    settle();
    write_cfg(kpdc_pkg::CFG_PRESS_TH, p, 1'b1);
    write_cfg(CFG_UNUSED_IDX, 8'($urandom), 1'b1);
    write_cfg(kpdc_pkg::CFG_LONG_TH, l, 1'b1);
    write_cfg(kpdc_pkg::CFG_VLONG_TH, v, 1'b0);
  endtask

  function automatic int unsigned pick_hold();
    int unsigned r;
    r = $urandom_range(99);
    if (r < 40) return $urandom_range(1, 6);
    if (r < 70) return $urandom_range(7, 90);
    return $urandom_range(150, 260);
  endfunction

  task automatic random_ticks(input int unsigned n);
    logic [1:0] lv;
    repeat (n) begin
      for (int k = 0; k < 2; k++) begin
        if (run_left[k] == 0) begin
          key_down[k] = ~key_down[k];
          run_left[k] = key_down[k] ? pick_hold() : $urandom_range(1, 5);
        end
        run_left[k]--;
      end
      lv = ~key_down;
      if ($urandom_range(99) < 8) lv = lv ^ 2'($urandom_range(1, 3));
      send_tick(lv);
    end
  endtask

  task automatic random_small_segment(input int unsigned n);
    logic [7:0] p, l, v;
    p = 8'($urandom_range(0, 6));
    l = p + 8'($urandom_range(0, 12));
    v = l + 8'($urandom_range(0, 30));
    set_thresholds(p, l, v);
    random_ticks(n);
  endtask

  task automatic random_full_segment(input int unsigned n);
    set_thresholds(8'($urandom_range(0, 255)), 8'($urandom_range(0, 255)),
                   8'($urandom_range(0, 255)));
    random_ticks(n);
  endtask

  // All three levels pass at once, so only the first key's press and long events are kept.
  task automatic test_stacked_levels();
    set_thresholds(8'd0, 8'd0, 8'd0);
    send_tick(2'b00);
    send_tick(2'b11);
    send_tick(2'b11);
    send_tick(2'b01);
    send_tick(2'b10);
    send_tick(2'b11);
    send_tick(2'b00);
    send_tick(2'b11);
  endtask

  task automatic test_nested_thresholds();
    set_thresholds(8'd200, 8'd0, 8'd0);
    repeat (5) send_tick(2'b10);
    send_tick(2'b11);
    set_thresholds(8'd0, 8'd255, 8'd0);
    send_tick(2'b01);
    send_tick(2'b11);
  endtask

  task automatic test_release_tick_trigger();
    set_thresholds(8'd255, 8'd255, 8'd255);
    repeat (4) send_tick(2'b10);
    set_thresholds(8'd3, 8'd255, 8'd255);
    send_tick(2'b11);
    send_tick(2'b11);
  endtask

  task automatic test_random_slow_receiver();
    set_thresholds(kpdc_pkg::PRESS_TH_RST, kpdc_pkg::LONG_TH_RST, kpdc_pkg::VLONG_TH_RST);
    random_ticks(100);
    random_small_segment(100);
    random_full_segment(100);
    set_thresholds(8'd0, 8'd0, 8'd0);
    random_ticks(100);
  endtask

  task automatic test_random_slow_sender();
    set_thresholds(8'd255, 8'd255, 8'd255);
    random_ticks(100);
    random_small_segment(100);
    random_full_segment(100);
    set_thresholds(8'd0, 8'd255, 8'd0);
    random_ticks(100);
  endtask

  task automatic test_random_full_rate();
    set_thresholds(8'd238, 8'd238, 8'd238);
    random_ticks(100);
    random_small_segment(100);
    random_full_segment(100);
    set_thresholds(kpdc_pkg::PRESS_TH_RST, kpdc_pkg::LONG_TH_RST, kpdc_pkg::VLONG_TH_RST);
    random_ticks(100);
  endtask

  initial begin
    repeat (10) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);
    send_idle_pct = 35;
    recv_idle_pct = 64;
    test_stacked_levels();
    test_nested_thresholds();
    test_release_tick_trigger();
    test_random_slow_receiver();
    send_idle_pct = 64;
    recv_idle_pct = 35;
    test_random_slow_sender();
    send_idle_pct = 0;
    recv_idle_pct = 0;
    test_random_full_rate();
    settle();
    if (fail_count == 0) begin
      $display("[ OK ] regression clean");
    end else begin
      $display("[FAIL] regression broken");
    end
    $finish;
  end

  initial begin
    #5_000_000;
    $display("[FAIL] regression broken");
    $finish;
  end

endmodule

[files.f]
+incdir+hdl
hdl/kpdc_pkg.sv
hdl/kpdc_lane.sv
hdl/kpdc_merge.sv
hdl/key_press_duration_classifier_unit.sv
sim/key_press_duration_classifier_unit_test.sv
